// ----- design/i2j_pkg.sv -----
// Shared types, codes and constants of the ISO-2022-JP decoder.
`timescale 1ns / 1ps

package i2j_pkg;

   // Field widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned RUNE_W     = 16;
   localparam int unsigned IDX_W      = 14;
   localparam int unsigned LIMIT_W    = 15;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned TBL_W      = RUNE_W + 1;

   // Default table depth and register reset values
   localparam int unsigned TABLE_DEPTH_DEF = 16384;
   localparam logic [RUNE_W-1:0]  BAD_RUNE_RST = 16'hFFFD;
   localparam logic [LIMIT_W-1:0] LIMIT_RST    = 15'd9596;

   // Register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_BAD_RUNE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DROP     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT    = 2'd2;

   // Commands carried by an input transfer
   typedef enum logic [CMD_W-1:0] {
      CMD_DATA = 2'd0,
      CMD_EOS  = 2'd1,
      CMD_LOAD = 2'd2
   } cmd_type;

   // Parser phases
   typedef enum logic [4:0] {
      PH_IDLE       = 5'b00001,
      PH_ESC        = 5'b00010,
      PH_ESC_DOLLAR = 5'b00100,
      PH_ESC_PAREN  = 5'b01000,
      PH_SECOND     = 5'b10000
   } phase_type;

   // Characters of the escape sequences and the Roman set
   localparam logic [BYTE_W-1:0] ESC_CH    = 8'h1B;
   localparam logic [BYTE_W-1:0] DOLLAR_CH = 8'h24;
   localparam logic [BYTE_W-1:0] PAREN_CH  = 8'h28;
   localparam logic [BYTE_W-1:0] AT_CH     = 8'h40;
   localparam logic [BYTE_W-1:0] B_CH      = 8'h42;
   localparam logic [BYTE_W-1:0] H_CH      = 8'h48;
   localparam logic [BYTE_W-1:0] J_CH      = 8'h4A;
   localparam logic [BYTE_W-1:0] BSL_CH    = 8'h5C;
   localparam logic [BYTE_W-1:0] TILDE_CH  = 8'h7E;
   localparam logic [RUNE_W-1:0] YEN_RUNE    = 16'h00A5;
   localparam logic [RUNE_W-1:0] MACRON_RUNE = 16'h00AF;

   // Kuten index arithmetic
   localparam logic [BYTE_W-1:0] EOS_TRAIL  = 8'h21;
   localparam int unsigned       KUTEN_ROW  = 100;
   localparam int unsigned       KUTEN_BASE = 3232;

   // One decoded input item on its way to the output stage
   typedef struct packed {
      logic [1:0]             cnt;      // fixed results held in runes
      logic [2:0][RUNE_W-1:0] runes;    // fixed results, first in slot 0
      logic                   lookup;   // single result taken from the table
      logic                   pre_bad;  // index is unmapped before the table read
   } item_type;

endpackage

// ----- design/iso2022jp_decoder.sv -----
// Top level of the ISO-2022-JP stream decoder.
`timescale 1ns / 1ps

// The decoder takes one input transfer per cycle while the output stage can take
// it and the table sweep is over: a data byte, an end-of-stream mark or a kuten
// table load (the command travels in req_tuser). Escape and pair state sits in
// the parser, and the kuten table in a single synchronous RAM that is read when the
// trail byte (or an end of stream after a lead) is accepted and answered in the
// next cycle in the output stage, from which each result goes out through the
// output register. An item holds the output stage until it has sent every result
// it causes, so a failed escape or a broken pair, with more results, holds back the
// input longer. After reset the table is swept to "unmapped", one entry per cycle
// over all entries with req_tready low; configuration writes are taken at any time.
module iso2022jp_decoder
   import i2j_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // byte_in, entry_index, entry_code, entry_mapped
   input  logic [CMD_W-1:0]      req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RUNE_W-1:0]     rsp_tdata,   // rune
   output logic                  rsp_tuser,   // substituted
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);

   logic [RUNE_W-1:0]  bad_rune_ff;
   logic               drop_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               clr_busy_ff;
   logic [AW-1:0]      clr_addr_ff;

   cmd_type            cmd;
   logic [BYTE_W-1:0]  byte_in;
   logic [IDX_W-1:0]   entry_index;
   logic [RUNE_W-1:0]  entry_code;
   logic               entry_mapped;

   logic               accept, s1_free, load_we;
   item_type           item;
   logic [IDX_W-1:0]   lookup_idx;
   logic               tbl_we, tbl_re;
   logic [AW-1:0]      tbl_waddr;
   logic [TBL_W-1:0]   tbl_wdata, tbl_rdata;

   // Input fields
   assign cmd          = cmd_type'(req_tuser);
   assign byte_in      = req_tdata[7:0];
   assign entry_index  = req_tdata[21:8];
   assign entry_code   = req_tdata[37:22];
   assign entry_mapped = req_tdata[38];

   assign req_tready = !clr_busy_ff && s1_free;
   assign accept     = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bad_rune_ff <= BAD_RUNE_RST;
         drop_ff     <= 1'b0;
         limit_ff    <= LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BAD_RUNE: bad_rune_ff <= csr_wdata;
            CSR_DROP:     drop_ff     <= csr_wdata[0];
            CSR_LIMIT:    limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default:      ;
         endcase
      end
   end

   // Clearing sweep of the table after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Table port: the sweep or a load writes, a trail byte or an end of stream after a lead reads.
   assign load_we   = accept && (cmd == CMD_LOAD)
                    && ({1'b0, entry_index} < LIMIT_W'(TABLE_DEPTH));
   assign tbl_we    = clr_busy_ff || load_we;
   assign tbl_waddr = clr_busy_ff ? clr_addr_ff : entry_index[AW-1:0];
   assign tbl_wdata = clr_busy_ff ? '0 : {entry_mapped, entry_code};
   assign tbl_re    = accept && item.lookup;

   i2j_parse #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (cmd),
      .byte_in     (byte_in),
      .index_limit (limit_ff),
      .item        (item),
      .lookup_idx  (lookup_idx)
   );

   i2j_ram #(
      .WIDTH (TBL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr (lookup_idx[AW-1:0]),
      .rdata (tbl_rdata)
   );

   i2j_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .item_in       (item),
      .tbl_rdata     (tbl_rdata),
      .bad_rune      (bad_rune_ff),
      .drop_unmapped (drop_ff),
      .free          (s1_free),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

   // No input transfer is taken while the sweep is running.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("input taken during table sweep");

   // The sweep ends only after reaching the last table entry.
   a_sweep_full: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> ($past(clr_addr_ff) == AW'(TABLE_DEPTH - 1)))
      else $error("table sweep ended early");

   // A substituted result always carries the replacement code point.
   a_sub_rune: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == bad_rune_ff))
      else $error("substituted result without replacement rune");

endmodule

// ----- design/i2j_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module i2j_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read; a read of the entry being written returns old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/i2j_parse.sv -----
// Escape and byte-pair parser: holds the decoder modes and decodes one input item.
`timescale 1ns / 1ps

module i2j_parse
   import i2j_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  cmd_type            cmd,
   input  logic [BYTE_W-1:0]  byte_in,
   input  logic [LIMIT_W-1:0] index_limit,
   output item_type           item,
   output logic [IDX_W-1:0]   lookup_idx
);

   phase_type         phase_ff, phase_in;
   logic              dbl_ff, dbl_in;
   logic              roman_ff, roman_in;
   logic [BYTE_W-1:0] lead_ff, lead_in;

   logic              is_data, is_eos;
   logic              idle_emit, idle_lead;
   logic [RUNE_W-1:0] idle_rune;
   phase_type         idle_phase;
   logic [BYTE_W-1:0] trail;
   logic [IDX_W-1:0]  kuten_sum;
   logic              below_base;

   assign is_data = (cmd == CMD_DATA);
   assign is_eos  = (cmd == CMD_EOS);

   // What the byte does when taken in the idle phase (also after a failed prefix).
   always_comb begin
      idle_emit  = 1'b0;
      idle_lead  = 1'b0;
      idle_rune  = {{(RUNE_W-BYTE_W){1'b0}}, byte_in};
      idle_phase = PH_IDLE;
      if (is_data) begin
         if (byte_in == ESC_CH) begin
            idle_phase = PH_ESC;
         end else if (!dbl_ff && !byte_in[BYTE_W-1]) begin
            idle_emit = 1'b1;
            if (roman_ff && byte_in == BSL_CH) begin
               idle_rune = YEN_RUNE;
            end else if (roman_ff && byte_in == TILDE_CH) begin
               idle_rune = MACRON_RUNE;
            end
         end else begin
            idle_phase = PH_SECOND;
            idle_lead  = 1'b1;
         end
      end
   end

   // Kuten index of the lead byte and the trail (end of stream supplies a filler trail).
   assign trail = is_eos ? (EOS_TRAIL | {lead_ff[BYTE_W-1], {(BYTE_W-1){1'b0}}}) : byte_in;
   assign kuten_sum = ({{(IDX_W-7){1'b0}}, lead_ff[6:0]} * IDX_W'(KUTEN_ROW))
                    + {{(IDX_W-7){1'b0}}, trail[6:0]};
   assign below_base = (kuten_sum < IDX_W'(KUTEN_BASE));
   assign lookup_idx = kuten_sum - IDX_W'(KUTEN_BASE);

   // Phase transitions and the results each item causes.
   always_comb begin
      item     = '0;
      phase_in = phase_ff;
      dbl_in   = dbl_ff;
      roman_in = roman_ff;
      lead_in  = lead_ff;
      if (is_data || is_eos) begin
         unique case (phase_ff) inside
            PH_ESC: begin
               if (is_data && byte_in == DOLLAR_CH) begin
                  phase_in = PH_ESC_DOLLAR;
               end else if (is_data && byte_in == PAREN_CH) begin
                  phase_in = PH_ESC_PAREN;
               end else begin
                  item.runes[0] = {{(RUNE_W-BYTE_W){1'b0}}, ESC_CH};
                  item.runes[1] = idle_rune;
                  item.cnt      = 2'd1 + {1'b0, idle_emit};
                  phase_in      = idle_phase;
                  if (idle_lead) begin
                     lead_in = byte_in;
                  end
               end
            end
            PH_ESC_DOLLAR, PH_ESC_PAREN: begin
               if (phase_ff == PH_ESC_DOLLAR && is_data
                   && (byte_in == AT_CH || byte_in == B_CH)) begin
                  dbl_in   = 1'b1;
                  phase_in = PH_IDLE;
               end else if (phase_ff == PH_ESC_PAREN && is_data
                            && (byte_in == J_CH || byte_in == H_CH || byte_in == B_CH)) begin
                  roman_in = (byte_in == J_CH);
                  dbl_in   = 1'b0;
                  phase_in = PH_IDLE;
               end else begin
                  item.runes[0] = {{(RUNE_W-BYTE_W){1'b0}}, ESC_CH};
                  item.runes[1] = {{(RUNE_W-BYTE_W){1'b0}},
                                   (phase_ff == PH_ESC_DOLLAR) ? DOLLAR_CH : PAREN_CH};
                  item.runes[2] = idle_rune;
                  item.cnt      = 2'd2 + {1'b0, idle_emit};
                  phase_in      = idle_phase;
                  if (idle_lead) begin
                     lead_in = byte_in;
                  end
               end
            end
            PH_SECOND: begin
               if (lead_ff[BYTE_W-1] != trail[BYTE_W-1]) begin
                  // Lead and trail disagree in the high bit: the lead goes out raw.
                  item.runes[0] = {{(RUNE_W-BYTE_W){1'b0}}, lead_ff};
                  item.runes[1] = idle_rune;
                  item.cnt      = 2'd1 + {1'b0, idle_emit};
                  phase_in      = idle_phase;
                  if (idle_lead) begin
                     lead_in = byte_in;
                  end
               end else begin
                  item.lookup  = 1'b1;
                  item.pre_bad = below_base
                               || ({1'b0, lookup_idx} >= index_limit)
                               || ({1'b0, lookup_idx} >= LIMIT_W'(TABLE_DEPTH));
                  phase_in     = PH_IDLE;
               end
            end
            PH_IDLE: begin
               item.runes[0] = idle_rune;
               item.cnt      = {1'b0, idle_emit};
               phase_in      = idle_phase;
               if (idle_lead) begin
                  lead_in = byte_in;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Mode registers advance on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         dbl_ff   <= 1'b0;
         roman_ff <= 1'b0;
         lead_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         dbl_ff   <= dbl_in;
         roman_ff <= roman_in;
         lead_ff  <= lead_in;
      end
   end

endmodule

// ----- design/i2j_emit.sv -----
// Output stage: resolves the table read and sends an item's results one per transfer.
`timescale 1ns / 1ps

module i2j_emit
   import i2j_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  item_type          item_in,
   input  logic [TBL_W-1:0]  tbl_rdata,
   input  logic [RUNE_W-1:0] bad_rune,
   input  logic              drop_unmapped,
   output logic              free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RUNE_W-1:0] rsp_tdata,   // rune
   output logic              rsp_tuser,   // substituted
   output logic              rsp_tlast
);

   logic              s1_valid_ff;
   item_type          s1_item_ff;
   logic [1:0]        s1_pos_ff;
   logic              rsp_valid_ff;
   logic [RUNE_W-1:0] rsp_rune_ff;
   logic              rsp_sub_ff;
   logic              rsp_last_ff;

   logic              unmapped;
   logic [1:0]        total;
   logic [RUNE_W-1:0] cur_rune;
   logic              cur_sub;
   logic              rsp_free, has_more, fire, is_final;

   // Result count and current result; a table item yields its entry or the replacement.
   always_comb begin
      unmapped = s1_item_ff.pre_bad || !tbl_rdata[RUNE_W];
      cur_sub  = 1'b0;
      if (s1_item_ff.lookup) begin
         total    = (unmapped && drop_unmapped) ? 2'd0 : 2'd1;
         cur_rune = unmapped ? bad_rune : tbl_rdata[RUNE_W-1:0];
         cur_sub  = unmapped;
      end else begin
         total = s1_item_ff.cnt;
         case (s1_pos_ff)
            2'd0:    cur_rune = s1_item_ff.runes[0];
            2'd1:    cur_rune = s1_item_ff.runes[1];
            default: cur_rune = s1_item_ff.runes[2];
         endcase
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign has_more = s1_valid_ff && (s1_pos_ff < total);
   assign fire     = has_more && rsp_free;
   assign is_final = (s1_pos_ff == total - 2'd1);
   assign free     = !has_more || (fire && is_final);

   // Control state of the holding stage and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            s1_valid_ff <= 1'b1;
            s1_pos_ff   <= '0;
         end else if (free) begin
            s1_valid_ff <= 1'b0;
         end else if (fire) begin
            s1_pos_ff <= s1_pos_ff + 2'd1;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         s1_item_ff <= item_in;
      end
      if (fire) begin
         rsp_rune_ff <= cur_rune;
         rsp_sub_ff  <= cur_sub;
         rsp_last_ff <= is_final;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rune_ff;
   assign rsp_tuser  = rsp_sub_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The result pointer never runs past the item's result count.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_pos_ff <= total))
      else $error("result pointer beyond result count");

   // A new item is taken only once the held item has sent its last result.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("item loaded over unfinished results");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of the ISO-2022-JP decoder, with a stream driver, monitor and predictor.
`timescale 1ns / 1ps

module testbench;
   import i2j_pkg::*;

   // The command code that the block must ignore.
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // One input transfer before packing, and one result transfer.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] byte_in;
      logic [IDX_W-1:0]  entry_index;
      logic [RUNE_W-1:0] entry_code;
      logic              entry_mapped;
   } req_item_type;

   typedef struct packed {
      logic [RUNE_W-1:0] rune;
      logic              sub;
      logic              last;
   } rune_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [39:0]           req_tdata;   // byte_in, entry_index, entry_code, entry_mapped
   logic [CMD_W-1:0]      req_tuser;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RUNE_W-1:0]     rsp_tdata;   // rune
   logic                  rsp_tuser;   // substituted
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   iso2022jp_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Stimulus, expectations and run bookkeeping.
   req_item_type  stream_items[$];
   rune_item_type expected_runes[$];
   rune_item_type step_runes[$];
   logic [BYTE_W-1:0] pair_leads[$];
   logic [BYTE_W-1:0] pair_trails[$];
   req_item_type  req_hold;
   logic    req_fired;
   bit      hold_rsp = 1'b0;
   int      items_taken = 0;
   int      items_queued = 0;
   int      fail_count = 0;
   wire     calm = (items_taken >= 300) && (items_taken < 380);

   // Predictor state and its copy of the registers.
   phase_type          dec_phase = PH_IDLE;
   bit                 dbl_mode = 1'b0;
   bit                 roman = 1'b0;
   logic [BYTE_W-1:0]  lead_byte = '0;
   bit [RUNE_W-1:0]    kuten_code [TABLE_DEPTH_DEF];
   bit                 kuten_mapped [TABLE_DEPTH_DEF];
   logic [RUNE_W-1:0]  cfg_bad_rune = BAD_RUNE_RST;
   logic               cfg_drop = 1'b0;
   logic [LIMIT_W-1:0] cfg_limit = LIMIT_RST;

   // A transfer never carries more than three results.
   function automatic void emit_rune(logic [RUNE_W-1:0] v, logic s);
      rune_item_type r;
      if (step_runes.size() < 3) begin
         r.rune = v;
         r.sub  = s;
         r.last = 1'b0;
         step_runes.push_back(r);
      end
   endfunction

   // Runs one stream byte, or the end of the stream when c is negative.
   function automatic void feed_stream(int c);
      int                kuten;
      logic [BYTE_W-1:0] trail_b;
      bit                again;
      do begin
         again = 1'b0;
         case (dec_phase)
            PH_ESC: begin
               if (c == int'(DOLLAR_CH)) begin
                  dec_phase = PH_ESC_DOLLAR;
               end else if (c == int'(PAREN_CH)) begin
                  dec_phase = PH_ESC_PAREN;
               end else begin
                  emit_rune(RUNE_W'(ESC_CH), 1'b0);
                  dec_phase = PH_IDLE;
                  again = 1'b1;
               end
            end
            PH_ESC_DOLLAR: begin
               if (c == int'(AT_CH) || c == int'(B_CH)) begin
                  dbl_mode = 1'b1;
                  dec_phase = PH_IDLE;
               end else begin
                  emit_rune(RUNE_W'(ESC_CH), 1'b0);
                  emit_rune(RUNE_W'(DOLLAR_CH), 1'b0);
                  dec_phase = PH_IDLE;
                  again = 1'b1;
               end
            end
            PH_ESC_PAREN: begin
               if (c == int'(J_CH) || c == int'(H_CH) || c == int'(B_CH)) begin
                  roman = (c == int'(J_CH));
                  dbl_mode = 1'b0;
                  dec_phase = PH_IDLE;
               end else begin
                  emit_rune(RUNE_W'(ESC_CH), 1'b0);
                  emit_rune(RUNE_W'(PAREN_CH), 1'b0);
                  dec_phase = PH_IDLE;
                  again = 1'b1;
               end
            end
            PH_SECOND: begin
               // The end of the stream stands in for a trail byte of the lead's kind.
               if (c < 0)
                  trail_b = EOS_TRAIL | {lead_byte[7], 7'b0};
               else
                  trail_b = c[7:0];
               dec_phase = PH_IDLE;
               if (lead_byte[7] != trail_b[7]) begin
                  emit_rune(RUNE_W'(lead_byte), 1'b0);
                  again = 1'b1;
               end else begin
                  kuten = int'(lead_byte[6:0]) * int'(KUTEN_ROW) + int'(trail_b[6:0])
                          - int'(KUTEN_BASE);
                  if (kuten < 0 || kuten >= int'(cfg_limit)
                      || kuten >= int'(TABLE_DEPTH_DEF) || !kuten_mapped[kuten]) begin
                     if (!cfg_drop)
                        emit_rune(cfg_bad_rune, 1'b1);
                  end else begin
                     emit_rune(kuten_code[kuten], 1'b0);
                  end
               end
            end
            default: begin
               dec_phase = PH_IDLE;
               if (c == int'(ESC_CH)) begin
                  dec_phase = PH_ESC;
               end else if (c >= 0) begin
                  if (!dbl_mode && c < 128) begin
                     if (roman && c == int'(BSL_CH))
                        emit_rune(YEN_RUNE, 1'b0);
                     else if (roman && c == int'(TILDE_CH))
                        emit_rune(MACRON_RUNE, 1'b0);
                     else
                        emit_rune(RUNE_W'(c), 1'b0);
                  end else begin
                     lead_byte = c[7:0];
                     dec_phase = PH_SECOND;
                  end
               end
            end
         endcase
      end while (again);
   endfunction

   // Works out the results of one accepted input transfer.
   function automatic void decode_item(req_item_type it);
      step_runes.delete();
      case (it.cmd)
         CMD_DATA: feed_stream(int'(it.byte_in));
         CMD_EOS:  feed_stream(-1);
         CMD_LOAD: begin
            kuten_code[it.entry_index]   = it.entry_code;
            kuten_mapped[it.entry_index] = it.entry_mapped;
         end
         default: ;
      endcase
      if (step_runes.size() != 0)
         step_runes[step_runes.size() - 1].last = 1'b1;
      foreach (step_runes[i])
         expected_runes.push_back(step_runes[i]);
   endfunction

   // Stimulus builders; fields that a command ignores carry random values.
   function automatic void push_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                     logic [IDX_W-1:0] idx, logic [RUNE_W-1:0] code,
                                     logic mapped);
      req_item_type r;
      r.cmd          = cmd;
      r.byte_in      = b;
      r.entry_index  = idx;
      r.entry_code   = code;
      r.entry_mapped = mapped;
      stream_items.push_back(r);
      items_queued++;
   endfunction

   function automatic void push_byte(logic [BYTE_W-1:0] b);
      push_item(CMD_DATA, b, IDX_W'($urandom), RUNE_W'($urandom), 1'($urandom));
   endfunction

   function automatic void push_eos();
      push_item(CMD_EOS, BYTE_W'($urandom), IDX_W'($urandom), RUNE_W'($urandom),
                1'($urandom));
   endfunction

   function automatic void push_load(logic [IDX_W-1:0] idx, logic [RUNE_W-1:0] code,
                                     logic mapped);
      push_item(CMD_LOAD, BYTE_W'($urandom), idx, code, mapped);
   endfunction

   // Random traffic: mostly well-formed escapes, loaded pairs and text, plus noise.
   task automatic add_random(int n);
      int                kind;
      int                pick;
      int                target;
      logic [BYTE_W-1:0] ld;
      logic [BYTE_W-1:0] tr;
      logic [BYTE_W-1:0] hb;
      target = items_queued + n;
      while (items_queued < target) begin
         kind = $urandom_range(99);
         hb = $urandom_range(1) ? 8'h80 : 8'h00;
         if (kind < 25) begin
            pick = $urandom_range(9);
            if (pick == 0)
               push_byte(BSL_CH);
            else if (pick == 1)
               push_byte(TILDE_CH);
            else
               push_byte(BYTE_W'($urandom_range(127)));
         end else if (kind < 40) begin
            push_byte(ESC_CH);
            if ($urandom_range(1)) begin
               push_byte(DOLLAR_CH);
               push_byte($urandom_range(1) ? AT_CH : B_CH);
            end else begin
               push_byte(PAREN_CH);
               pick = $urandom_range(2);
               push_byte(pick == 0 ? J_CH : (pick == 1 ? H_CH : B_CH));
            end
         end else if (kind < 65) begin
            if (pair_leads.size() != 0 && $urandom_range(3) != 0) begin
               pick = $urandom_range(pair_leads.size() - 1);
               ld = pair_leads[pick];
               tr = pair_trails[pick];
            end else begin
               ld = BYTE_W'($urandom_range(127)) | hb;
               tr = BYTE_W'($urandom_range(127)) | hb;
            end
            push_byte(ld);
            push_byte(tr);
         end else if (kind < 77) begin
            ld = BYTE_W'($urandom_range(8'h7F, 8'h21)) | hb;
            tr = BYTE_W'($urandom_range(8'h7F, 8'h21)) | hb;
            push_load(IDX_W'(int'(ld[6:0]) * int'(KUTEN_ROW) + int'(tr[6:0])
                             - int'(KUTEN_BASE)),
                      RUNE_W'($urandom), $urandom_range(9) != 0);
            pair_leads.push_back(ld);
            pair_trails.push_back(tr);
         end else if (kind < 82) begin
            push_eos();
         end else if (kind < 88) begin
            // An escape that goes wrong after its first or second byte.
            push_byte(ESC_CH);
            pick = $urandom_range(2);
            if (pick == 1)
               push_byte(DOLLAR_CH);
            else if (pick == 2)
               push_byte(PAREN_CH);
            push_byte(BYTE_W'($urandom_range(255)));
         end else if (kind < 94) begin
            ld = BYTE_W'($urandom_range(255));
            tr = BYTE_W'($urandom_range(255));
            tr[7] = ~ld[7];
            push_byte(ld);
            push_byte(tr);
         end else if (kind < 98) begin
            push_byte(BYTE_W'($urandom_range(255)));
         end else begin
            push_load(IDX_W'($urandom_range(TABLE_DEPTH_DEF - 1)), RUNE_W'($urandom),
                      1'($urandom));
         end
      end
   endtask

   // Register write; the predictor takes the new value at once since the block is idle.
   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_BAD_RUNE: cfg_bad_rune = val;
         CSR_DROP:     cfg_drop = val[0];
         CSR_LIMIT:    cfg_limit = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until every item is sent and every result is in, then lets the pipeline settle.
   task automatic drain(int settle);
      while (stream_items.size() != 0 || req_tvalid || expected_runes.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Input driver: a new item is offered once the previous one has been transferred.
   always @(negedge clock) begin
      if (!req_tvalid || req_fired) begin
         if (stream_items.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
            req_hold = stream_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, req_hold.entry_mapped, req_hold.entry_code,
                           req_hold.entry_index, req_hold.byte_in};
            req_tuser  <= req_hold.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver with random stalls and one long hold-off.
   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && (calm || $urandom_range(99) >= 16);
   end

   // Monitor: predicts on each input transfer and checks each result transfer.
   always @(posedge clock) begin
      rune_item_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            decode_item(req_hold);
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_runes.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: rune %h sub %0d last %0d",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_runes.pop_front();
               if (rsp_tdata !== want.rune || rsp_tuser !== want.sub
                   || rsp_tlast !== want.last) begin
                  if (fail_count < 10)
                     $display("mismatch: expected rune %h sub %0d last %0d,",
                              want.rune, want.sub, want.last,
                              " got rune %h sub %0d last %0d",
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   // Long hold-off on the result side so that the block fills and stalls its input.
   initial begin
      while (items_taken < 200) @(negedge clock);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("** iso2022jp_decoder: FAILED **");
      $finish;
   end

   // Main sequence: reset, directed items, then random phases under several settings.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset settings.
      push_load(IDX_W'(1601), 16'h4E9C, 1'b1);
      push_load(IDX_W'(TABLE_DEPTH_DEF - 1), 16'hFFFF, 1'b1);
      push_load(IDX_W'(0), 16'h1234, 1'b1);
      push_byte(8'h00);
      push_byte(ESC_CH);
      push_byte(PAREN_CH);
      push_byte(J_CH);
      push_byte(BSL_CH);
      push_byte(TILDE_CH);
      push_byte(ESC_CH);
      push_byte(DOLLAR_CH);
      push_byte(B_CH);
      push_byte(8'h30);
      push_byte(8'h21);
      // Pair with a negative index.
      push_byte(8'h01);
      push_byte(8'h01);
      // Lead and trail disagree in the top bit.
      push_byte(8'hB0);
      push_byte(8'h21);
      // End of stream completes the pending lead.
      push_eos();
      // End of stream after an escape prefix.
      push_byte(ESC_CH);
      push_byte(PAREN_CH);
      push_eos();
      push_item(CMD_SPARE, 8'hFF, '1, '1, 1'b1);
      // Highest index, just under the reset limit.
      push_byte(8'hFF);
      push_byte(8'hFF);
      add_random(110);
      drain(8);

      write_csr(CSR_BAD_RUNE, 16'h0000);
      write_csr(CSR_DROP, 16'h0001);
      write_csr(CSR_LIMIT, 16'h4000);
      add_random(110);
      drain(8);

      // Limit of zero makes every pair unmapped.
      write_csr(CSR_BAD_RUNE, 16'hFFFF);
      write_csr(CSR_DROP, 16'h0000);
      write_csr(CSR_LIMIT, 16'h0000);
      add_random(60);
      drain(8);

      write_csr(CSR_BAD_RUNE, CSR_DATA_W'($urandom));
      write_csr(CSR_LIMIT, 16'd9595);
      add_random(90);
      drain(8);

      write_csr(CSR_BAD_RUNE, CSR_DATA_W'($urandom));
      write_csr(CSR_DROP, CSR_DATA_W'($urandom_range(1)));
      write_csr(CSR_LIMIT, CSR_DATA_W'($urandom_range(9595, 100)));
      add_random(75);
      drain(20);

      if (fail_count == 0)
         $display("** iso2022jp_decoder: PASSED **");
      else
         $display("** iso2022jp_decoder: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/i2j_pkg.sv
design/i2j_ram.sv
design/i2j_parse.sv
design/i2j_emit.sv
design/iso2022jp_decoder.sv
dv/testbench.sv
